// ===== rtl/dxtd_pkg.sv =====
// ----------------------------------------------------------------------------
// dxtd_pkg
// Shared types, register codes and fixed-point helpers for the DXT decoder.
// ----------------------------------------------------------------------------
package dxtd_pkg;

    localparam int unsigned MAX_SIDE = 4096;
    localparam int unsigned SIDE_W   = 13;

    typedef enum logic [1:0] {
        FMT_DXT1 = 2'd0,
        FMT_DXT3 = 2'd1,
        FMT_DXT5 = 2'd2
    } t_fmt;

    typedef enum logic [1:0] {
        REG_FORMAT = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [63:0] alpha_word;
        logic [63:0] color_word;
        logic [9:0]  block_col;
        logic [9:0]  block_row;
    } t_in_beat;

    typedef struct packed {
        logic [11:0] texel_x;
        logic [11:0] texel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last_of_block;
    } t_out_beat;

    // v * 255 / 31, folded into one constant multiply and a shift
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [26:0] p;
        begin
            p = 27'(v) * 27'd2156535;
            return p[25:18];
        end
    endfunction

    // v * 255 / 63
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [28:0] p;
        begin
            p = 29'(v) * 29'd4244475;
            return p[27:20];
        end
    endfunction

    // n / 3 for n up to 765
    function automatic logic [7:0] div3(input logic [9:0] n);
        logic [20:0] p;
        begin
            p = 21'(n) * 21'd1366;
            return p[19:12];
        end
    endfunction

    // n / 7 for n up to 1785
    function automatic logic [7:0] div7(input logic [10:0] n);
        logic [22:0] p;
        begin
            p = 23'(n) * 23'd2341;
            return p[21:14];
        end
    endfunction

    // n / 5 for n up to 1275
    function automatic logic [7:0] div5(input logic [10:0] n);
        logic [21:0] p;
        begin
            p = 22'(n) * 22'd1639;
            return p[20:13];
        end
    endfunction

endpackage

// ===== rtl/dxt_block_texture_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// dxt_block_texture_decoder_unit
// Decodes one DXT1/DXT3/DXT5 4x4 block per input beat into RGBA8 texel beats.
// An accepted block passes the stage-1, stage-2 and serializer registers
// before its first texel reaches the output. The serializer emits one
// texel per cycle unless the output stalls, and only texels inside the image
// (16 for an interior block); a block wholly outside it is dropped at stage 2.
// Reset: empties every stage and loads format DXT1 and a 4096 x 4096 image.
// ----------------------------------------------------------------------------
module dxt_block_texture_decoder_unit
    import dxtd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // block input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_beat    i_in_data,
    // texel output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_beat   o_out_data,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Block state after endpoint expansion and clip setup.
    typedef struct packed {
        logic [2:0][7:0] e0;
        logic [2:0][7:0] e1;
        logic            four;
        logic            a_gt;
        logic [31:0]     cidx;
        logic [63:0]     aword;
        logic [11:0]     x0;
        logic [11:0]     y0;
        logic [1:0]      last_col;
        logic [1:0]      last_row;
        logic            any;
    } t_mid;

    // Block state held by the texel serializer: full palettes.
    typedef struct packed {
        logic [3:0][2:0][7:0] pal;
        logic                 four;
        logic [7:0][7:0]      apal;
        logic [31:0]          cidx;
        logic [63:0]          aword;
        logic [11:0]          x0;
        logic [11:0]          y0;
        logic [1:0]           last_col;
        logic [1:0]           last_row;
    } t_ser;

    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]        r_format_mode;
    logic [SIDE_W-1:0] r_image_width;
    logic [SIDE_W-1:0] r_image_height;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_mode  <= FMT_DXT1;
            r_image_width  <= SIDE_MAX;
            r_image_height <= SIDE_MAX;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_FORMAT: r_format_mode  <= pwdata[1:0];
                REG_WIDTH:  r_image_width  <= pwdata[SIDE_W-1:0];
                REG_HEIGHT: r_image_height <= pwdata[SIDE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_FORMAT: prdata = {30'd0, r_format_mode};
            REG_WIDTH:  prdata = {(32 - SIDE_W)'(0), r_image_width};
            REG_HEIGHT: prdata = {(32 - SIDE_W)'(0), r_image_height};
            default:    prdata = 32'd0;
        endcase
    end

    logic mode_dxt3, mode_dxt5;
    assign mode_dxt3 = (r_format_mode == FMT_DXT3);
    assign mode_dxt5 = (r_format_mode == FMT_DXT5);

    // ------------------------------------------------------------------
    // Pipeline control. Each stage advances when the one below it can
    // take its contents; the serializer frees after its last texel beat.
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_ser_valid, r_out_valid;
    t_in_beat  r_s1;
    t_mid      r_s2, n_s2;
    t_ser      r_ser, n_ser;
    t_out_beat r_out, n_out;
    logic [1:0] r_col, r_row;

    logic out_adv, ser_emit, ser_done, ser_free, ser_load;
    logic s2_go, s1_go, in_acc, tex_last;

    assign out_adv  = !r_out_valid || i_out_ready;
    assign ser_emit = r_ser_valid && out_adv;
    assign ser_done = ser_emit && tex_last;
    assign ser_free = !r_ser_valid || ser_done;
    // a block with no texel inside the image is dropped here
    assign s2_go    = !r_s2_valid || !r_s2.any || ser_free;
    assign ser_load = r_s2_valid && r_s2.any && ser_free;
    assign s1_go    = !r_s1_valid || s2_go;
    assign in_acc   = i_in_valid && s1_go;

    assign o_in_ready  = s1_go;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Stage 1 -> 2: expand RGB565 endpoints, pick the palette mode and
    // work out how many columns and rows of the block are visible.
    // ------------------------------------------------------------------
    logic [15:0]       c0, c1;
    logic [7:0]        a0_s1, a1_s1;
    logic [SIDE_W-1:0] w_eff, h_eff, bx4, by4, col_room, row_room;

    always_comb begin
        c0    = r_s1.color_word[15:0];
        c1    = r_s1.color_word[31:16];
        a0_s1 = r_s1.alpha_word[7:0];
        a1_s1 = r_s1.alpha_word[15:8];
        w_eff = (r_image_width  > SIDE_MAX) ? SIDE_MAX : r_image_width;
        h_eff = (r_image_height > SIDE_MAX) ? SIDE_MAX : r_image_height;
        bx4   = {1'b0, r_s1.block_col, 2'b00};
        by4   = {1'b0, r_s1.block_row, 2'b00};
        col_room = w_eff - bx4;
        row_room = h_eff - by4;

        n_s2.e0[0]  = widen5(c0[15:11]);
        n_s2.e0[1]  = widen6(c0[10:5]);
        n_s2.e0[2]  = widen5(c0[4:0]);
        n_s2.e1[0]  = widen5(c1[15:11]);
        n_s2.e1[1]  = widen6(c1[10:5]);
        n_s2.e1[2]  = widen5(c1[4:0]);
        n_s2.four   = mode_dxt3 || mode_dxt5 || (c0 > c1);
        n_s2.a_gt   = a0_s1 > a1_s1;
        n_s2.cidx   = r_s1.color_word[63:32];
        n_s2.aword  = r_s1.alpha_word;
        n_s2.x0     = bx4[11:0];
        n_s2.y0     = by4[11:0];
        n_s2.last_col = (col_room > SIDE_W'(3)) ? 2'd3 : (col_room[1:0] - 2'd1);
        n_s2.last_row = (row_room > SIDE_W'(3)) ? 2'd3 : (row_room[1:0] - 2'd1);
        n_s2.any    = (w_eff > bx4) && (h_eff > by4);
    end

    // ------------------------------------------------------------------
    // Stage 2 -> serializer: interpolate colour and alpha palettes.
    // ------------------------------------------------------------------
    logic [7:0]  a0_s2, a1_s2;
    logic [10:0] sum7 [1:6];
    logic [10:0] sum5 [1:4];
    logic [9:0]  mix2, mix3;
    logic [8:0]  half;

    always_comb begin
        a0_s2 = r_s2.aword[7:0];
        a1_s2 = r_s2.aword[15:8];
        mix2  = '0;
        mix3  = '0;
        half  = '0;
        n_ser.pal[0] = r_s2.e0;
        n_ser.pal[1] = r_s2.e1;
        for (int ch = 0; ch < 3; ch++) begin
            mix2 = {1'b0, r_s2.e0[ch], 1'b0} + 10'(r_s2.e1[ch]);
            mix3 = 10'(r_s2.e0[ch]) + {1'b0, r_s2.e1[ch], 1'b0};
            half = 9'(r_s2.e0[ch]) + 9'(r_s2.e1[ch]);
            if (r_s2.four) begin
                n_ser.pal[2][ch] = div3(mix2);
                n_ser.pal[3][ch] = div3(mix3);
            end else begin
                n_ser.pal[2][ch] = half[8:1];
                n_ser.pal[3][ch] = 8'd0;
            end
        end

        for (int k = 1; k <= 6; k++) begin
            sum7[k] = 11'(7 - k) * 11'(a0_s2) + 11'(k) * 11'(a1_s2);
        end
        for (int k = 1; k <= 4; k++) begin
            sum5[k] = 11'(5 - k) * 11'(a0_s2) + 11'(k) * 11'(a1_s2);
        end
        n_ser.apal[0] = a0_s2;
        n_ser.apal[1] = a1_s2;
        if (r_s2.a_gt) begin
            for (int k = 1; k <= 6; k++) begin
                n_ser.apal[k + 1] = div7(sum7[k]);
            end
        end else begin
            for (int k = 1; k <= 4; k++) begin
                n_ser.apal[k + 1] = div5(sum5[k]);
            end
            n_ser.apal[6] = 8'd0;
            n_ser.apal[7] = 8'd255;
        end

        n_ser.four     = r_s2.four;
        n_ser.cidx     = r_s2.cidx;
        n_ser.aword    = r_s2.aword;
        n_ser.x0       = r_s2.x0;
        n_ser.y0       = r_s2.y0;
        n_ser.last_col = r_s2.last_col;
        n_ser.last_row = r_s2.last_row;
    end

    // ------------------------------------------------------------------
    // Serializer -> output: pick one texel per cycle unless the output stalls,
    // walking only the visible columns and rows so clipped texels are skipped.
    // ------------------------------------------------------------------
    logic [3:0] tix;
    logic [1:0] ci;
    logic [3:0] a4;
    logic [5:0] aoff;
    logic [2:0] aidx;

    always_comb begin
        tix  = {r_row, r_col};
        ci   = r_ser.cidx[{tix, 1'b0} +: 2];
        a4   = r_ser.aword[{tix, 2'b00} +: 4];
        aoff = 6'd16 + 6'(tix) * 6'd3;
        aidx = r_ser.aword[aoff +: 3];
        tex_last = (r_col == r_ser.last_col) && (r_row == r_ser.last_row);

        n_out.texel_x = r_ser.x0 + 12'(r_col);
        n_out.texel_y = r_ser.y0 + 12'(r_row);
        n_out.red     = r_ser.pal[ci][0];
        n_out.green   = r_ser.pal[ci][1];
        n_out.blue    = r_ser.pal[ci][2];
        n_out.last_of_block = tex_last;
        if (mode_dxt3) begin
            n_out.alpha = {a4, a4};    // a4 * 17 == a4 * 255 / 15
        end else if (mode_dxt5) begin
            n_out.alpha = r_ser.apal[aidx];
        end else begin
            n_out.alpha = (!r_ser.four && ci == 2'd3) ? 8'd0 : 8'd255;
        end
    end

    // ------------------------------------------------------------------
    // Valid bits and serializer position
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_ser_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_col       <= 2'd0;
            r_row       <= 2'd0;
        end else begin
            if (s1_go) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_go) begin
                r_s2_valid <= r_s1_valid;
            end
            if (ser_load) begin
                r_ser_valid <= 1'b1;
            end else if (ser_done) begin
                r_ser_valid <= 1'b0;
            end
            if (out_adv) begin
                r_out_valid <= r_ser_valid;
            end
            // advance across the visible window, wrap at the row end
            if (ser_load) begin
                r_col <= 2'd0;
                r_row <= 2'd0;
            end else if (ser_emit) begin
                if (r_col == r_ser.last_col) begin
                    r_col <= 2'd0;
                    r_row <= r_row + 2'd1;
                end else begin
                    r_col <= r_col + 2'd1;
                end
            end
        end
    end

    // Payload registers: load only when the stage takes a new beat.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_in_data;
        end
        if (s2_go && r_s1_valid) begin
            r_s2 <= n_s2;
        end
        if (ser_load) begin
            r_ser <= n_ser;
        end
        if (ser_emit) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/dxtd_checker.sv =====
// ----------------------------------------------------------------------------
// dxtd_checker
// Port-level checks for the DXT block decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dxtd_checker
    import dxtd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_data
);

    // hold a stalled texel beat unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("texel beat dropped or changed while stalled");

    // input ready and no output beat right after reset
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("pipeline not empty after reset");

    // a block streams its texels without bubbles
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last_of_block |=> o_out_valid)
        else $error("gap inside a block's texel stream");

    // next texel of the same block is one column right or one row down
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last_of_block |=>
            (o_out_data.texel_x == $past(o_out_data.texel_x) + 12'd1) ||
            (o_out_data.texel_y == $past(o_out_data.texel_y) + 12'd1))
        else $error("texel order broken inside a block");

endmodule

bind dxt_block_texture_decoder_unit dxtd_checker u_dxtd_checker (.*);
